FILE: rtl/crsf_rc_frame_encoder_defines.svh
// assertion macros shared by the frame encoder modules
`ifndef CRSF_RC_FRAME_ENCODER_DEFINES_SVH
`define CRSF_RC_FRAME_ENCODER_DEFINES_SVH

// checked property, masked while reset is high
`define CRSF_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, also during reset
`define CRSF_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/crsf_enc_pkg.sv
`timescale 1ns / 1ps

package crsf_enc_pkg;

  // defaults for the top level parameters
  localparam int CHANNELS_DEF   = 8;
  localparam int TIMER_BITS_DEF = 16;

  // field widths
  localparam int CHAN_W        = 16;
  localparam int IN_CHANS      = 8;
  localparam int VAL_W         = 11;
  localparam int SLOTS         = 16;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int PAYLOAD_BYTES = 22;
  localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
  localparam int FRAME_LEN     = 26;
  localparam int BYTE_IDX_W    = $clog2(FRAME_LEN);
  localparam int SEND_W        = 10;
  localparam int TIMEOUT_W     = 16;
  localparam int CFG_W         = 16;

  // input kinds
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // register indexes
  localparam logic REG_SEND_INTERVAL = 1'b0;
  localparam logic REG_SILENCE_LIMIT = 1'b1;

  // register reset values
  localparam logic [SEND_W-1:0]    SEND_INTERVAL_RST = 10'd10;
  localparam logic [TIMEOUT_W-1:0] SILENCE_LIMIT_RST = 16'd150;

  // frame header and check
  localparam logic [7:0] FRAME_ADDR = 8'hC8;
  localparam logic [7:0] FRAME_SIZE = 8'd24;
  localparam logic [7:0] FRAME_TYPE = 8'h16;
  localparam logic [7:0] CRC_POLY   = 8'hD5;

  // byte positions inside the frame
  localparam logic [BYTE_IDX_W-1:0] BYTE_ADDR = 5'd0;
  localparam logic [BYTE_IDX_W-1:0] BYTE_SIZE = 5'd1;
  localparam logic [BYTE_IDX_W-1:0] BYTE_TYPE = 5'd2;
  localparam logic [BYTE_IDX_W-1:0] BYTE_CRC  = 5'd25;

  // channel range and mapping
  localparam logic [CHAN_W-1:0] CH_MIN      = 16'd1000;
  localparam logic [CHAN_W-1:0] CH_MAX      = 16'd2000;
  localparam logic [CHAN_W-1:0] CH_MID      = 16'd1500;
  localparam logic [VAL_W-1:0]  CH_OUT_MIN  = 11'd172;
  localparam int                THROTTLE_IDX = 2;

  // floor(d * 1639 / 1000) == (d * SCALE_MUL) >> SCALE_SHIFT for d in 0..1000
  localparam int               DIFF_W      = 10;
  localparam int               SCALE_SHIFT = 20;
  localparam int               MUL_W       = 21;
  localparam int               PROD_W      = DIFF_W + MUL_W;
  localparam logic [MUL_W-1:0] SCALE_MUL   = 21'd1718617;

  // control from the sequencer to the byte streamer
  typedef struct packed {
    logic             shift_en;
    logic [VAL_W-1:0] shift_val;
    logic             start;
    logic             failsafe;
  } ser_ctrl_t;

  // one byte of crc-8, msb first
  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/crsf_enc_scale.sv
`timescale 1ns / 1ps

module crsf_enc_scale import crsf_enc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_zero,
  input  logic [CHAN_W-1:0] in_chan,
  output logic              out_valid,
  output logic [VAL_W-1:0]  out_val
);

  logic [CHAN_W-1:0] clamped;
  logic [DIFF_W-1:0] diff;
  logic [PROD_W-1:0] prod_next;
  logic [PROD_W-1:0] prod;
  logic              zero;

  // clamp to the pulse range and take the offset
  always_comb begin
    if (in_chan < CH_MIN) begin
      clamped = CH_MIN;
    end else if (in_chan > CH_MAX) begin
      clamped = CH_MAX;
    end else begin
      clamped = in_chan;
    end
    diff      = DIFF_W'(clamped - CH_MIN);
    prod_next = PROD_W'(diff) * PROD_W'(SCALE_MUL);
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    prod <= prod_next;
    zero <= in_zero;
  end

  // unused slots read as zero
  assign out_val = zero ? '0 : (CH_OUT_MIN + prod[PROD_W-1:SCALE_SHIFT]);

endmodule

FILE: rtl/crsf_enc_serializer.sv
`timescale 1ns / 1ps
`include "crsf_rc_frame_encoder_defines.svh"

module crsf_enc_serializer import crsf_enc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ser_ctrl_t ctrl,
  output logic      busy,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic      m_axis_tlast,
  output logic      m_axis_tuser
);

  logic [PAYLOAD_BITS-1:0] payload;
  logic [BYTE_IDX_W-1:0]   byte_idx;
  logic [7:0]              crc;
  logic                    fs;
  logic [7:0]              cur;
  logic                    emit;
  logic                    in_crc;
  logic                    in_payload;

  assign emit       = busy && (!m_axis_tvalid || m_axis_tready);
  assign in_crc     = (byte_idx >= BYTE_TYPE) && (byte_idx != BYTE_CRC);
  assign in_payload = (byte_idx > BYTE_TYPE) && (byte_idx != BYTE_CRC);

  // byte select for the current frame position
  always_comb begin
    if (byte_idx == BYTE_ADDR) begin
      cur = FRAME_ADDR;
    end else if (byte_idx == BYTE_SIZE) begin
      cur = FRAME_SIZE;
    end else if (byte_idx == BYTE_TYPE) begin
      cur = FRAME_TYPE;
    end else if (byte_idx == BYTE_CRC) begin
      cur = crc;
    end else begin
      cur = payload[7:0];
    end
  end

  // payload packing, crc and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (ctrl.start) begin
        busy     <= 1'b1;
        byte_idx <= BYTE_ADDR;
        crc      <= '0;
        fs       <= ctrl.failsafe;
      end else if (emit) begin
        byte_idx <= byte_idx + 1'b1;
        if (byte_idx == BYTE_CRC) begin
          busy <= 1'b0;
        end
        if (in_crc) begin
          crc <= crc_step(crc, cur);
        end
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= cur;
        m_axis_tlast  <= (byte_idx == BYTE_CRC);
        m_axis_tuser  <= fs;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (ctrl.shift_en) begin
      payload <= {ctrl.shift_val, payload[PAYLOAD_BITS-1:VAL_W]};
    end else if (emit && in_payload) begin
      payload <= {8'd0, payload[PAYLOAD_BITS-1:8]};
    end
  end

  `CRSF_ASSERT(a_start_idle, clk, rst, ctrl.start |-> !busy, "frame started while streaming")
  `CRSF_ASSERT(a_start_head, clk, rst, ctrl.start |=> busy && byte_idx == BYTE_ADDR, "frame start lost")
  `CRSF_ASSERT(a_crc_ends, clk, rst, (emit && byte_idx == BYTE_CRC) |=> !busy && m_axis_tlast, "frame not closed")

endmodule

FILE: rtl/crsf_rc_frame_encoder.sv
`timescale 1ns / 1ps
`include "crsf_rc_frame_encoder_defines.svh"

// channel    direction  bus                      contents
// s_axis     in         tdata 128, tuser 1       packet channels or tick
// m_axis     out        tdata 8, tlast, tuser 1  frame bytes, failsafe mark
// cfg        in         we, index 1, wdata 16    send interval, failsafe timeout
//
// a packet, or a tick that sends nothing, leaves s_axis_tready high
// a tick that sends a frame holds s_axis_tready low while it runs:
// the 16 slots pass through the shared scaling multiplier and its
// register, a load state follows, then 26 bytes at one per cycle if m_axis
// is ready, then the encoder goes back to idle
// m_axis stalls stretch the byte phase; rst is synchronous and active high

module crsf_rc_frame_encoder import crsf_enc_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_CHANS*CHAN_W-1:0] s_axis_tdata,  // chan0 .. chan7
  input  logic                   s_axis_tuser,      // operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,      // frame_byte
  output logic                   m_axis_tlast,
  output logic                   m_axis_tuser,      // in_failsafe
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [SLOT_W-1:0]     SLOT_LAST = SLOT_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LOAD,
    ST_SEND
  } state_t;

  state_t                 state;
  logic [SEND_W-1:0]      send_interval;
  logic [TIMEOUT_W-1:0]   silence_limit;
  logic [CHAN_W-1:0]      stored [CHANNELS];
  logic [TIMER_BITS-1:0]  ticks_since_packet;
  logic [TIMER_BITS-1:0]  ticks_since_send;
  logic [TIMER_BITS-1:0]  pkt_inc;
  logic [TIMER_BITS-1:0]  send_inc;
  logic                   failsafe;
  logic [SLOT_W-1:0]      issue_idx;
  logic                   issue_done;
  logic [SLOT_W-1:0]      res_idx;
  logic                   accept;
  logic                   slot_used;
  logic [CHAN_W-1:0]      chan_sel;
  logic                   scale_out_valid;
  logic [VAL_W-1:0]       scale_out_val;
  logic                   ser_busy;
  ser_ctrl_t              ser_ctrl;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // saturating tick counts
  assign pkt_inc  = (ticks_since_packet == TIMER_MAX) ? ticks_since_packet
                                                      : ticks_since_packet + 1'b1;
  assign send_inc = (ticks_since_send == TIMER_MAX) ? ticks_since_send
                                                    : ticks_since_send + 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      send_interval <= SEND_INTERVAL_RST;
      silence_limit <= SILENCE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEND_INTERVAL: send_interval <= cfg_wdata[SEND_W-1:0];
        REG_SILENCE_LIMIT: silence_limit <= cfg_wdata[TIMEOUT_W-1:0];
        default:           ;
      endcase
    end
  end

  // stored channel values, written by a packet
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        stored[i] <= (i == THROTTLE_IDX) ? CH_MIN : CH_MID;
      end
    end else if (accept && s_axis_tuser == OP_PACKET) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (i < IN_CHANS) begin
          stored[i] <= s_axis_tdata[i*CHAN_W +: CHAN_W];
        end
      end
    end
  end

  // channel feeding the scaler: stored or failsafe value
  assign slot_used = ({1'b0, issue_idx} < (SLOT_W + 1)'(CHANNELS));
  always_comb begin
    if (failsafe) begin
      chan_sel = (issue_idx == SLOT_W'(THROTTLE_IDX)) ? CH_MIN : CH_MID;
    end else begin
      chan_sel = stored[issue_idx[IDX_W-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      ticks_since_packet <= '0;
      ticks_since_send   <= '0;
      failsafe           <= 1'b0;
      issue_idx          <= '0;
      issue_done         <= 1'b0;
      res_idx            <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == OP_PACKET) begin
              ticks_since_packet <= '0;
            end else begin
              ticks_since_packet <= pkt_inc;
              if (CMP_W'(send_inc) >= CMP_W'(send_interval)) begin
                ticks_since_send <= '0;
                failsafe   <= (CMP_W'(pkt_inc) > CMP_W'(silence_limit));
                issue_idx  <= '0;
                issue_done <= 1'b0;
                res_idx    <= '0;
                state      <= ST_SCALE;
              end else begin
                ticks_since_send <= send_inc;
              end
            end
          end
        end
        ST_SCALE: begin
          if (!issue_done) begin
            issue_idx <= issue_idx + 1'b1;
            if (issue_idx == SLOT_LAST) begin
              issue_done <= 1'b1;
            end
          end
          if (scale_out_valid) begin
            res_idx <= res_idx + 1'b1;
            if (res_idx == SLOT_LAST) begin
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (!ser_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  crsf_enc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (state == ST_SCALE && !issue_done),
    .in_zero   (!slot_used),
    .in_chan   (chan_sel),
    .out_valid (scale_out_valid),
    .out_val   (scale_out_val)
  );

  always_comb begin
    ser_ctrl.shift_en  = scale_out_valid;
    ser_ctrl.shift_val = scale_out_val;
    ser_ctrl.start     = (state == ST_LOAD);
    ser_ctrl.failsafe  = failsafe;
  end

  crsf_enc_serializer u_ser (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ser_ctrl),
    .busy          (ser_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `CRSF_ASSERT(a_idle_no_result, clk, rst, (state == ST_IDLE) |-> !scale_out_valid, "stray result")
  `CRSF_ASSERT(a_ready_not_busy, clk, rst, s_axis_tready |-> !ser_busy, "ready while streaming")
  `CRSF_ASSERT(a_pkt_saturates, clk, rst,
    (ticks_since_packet == TIMER_MAX) |=>
    (ticks_since_packet == TIMER_MAX || ticks_since_packet == '0), "silence count wrapped")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import crsf_enc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;

  // one radio packet or tick as it goes into the encoder
  typedef struct packed {
    logic                       op;
    logic [IN_CHANS*CHAN_W-1:0] chans;
  } radio_item_t;

  // one serial byte as it should leave the encoder
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       failsafe;
  } frame_byte_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_CHANS*CHAN_W-1:0] s_axis_tdata = '0;
  logic                       s_axis_tuser = OP_PACKET;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [7:0]                 m_axis_tdata;
  logic                       m_axis_tlast;
  logic                       m_axis_tuser;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = REG_SEND_INTERVAL;
  logic [CFG_W-1:0]           cfg_wdata = '0;

  radio_item_t radio_items_q[$];
  frame_byte_t frame_bytes_q[$];

  // mirror of the encoder state
  logic [CHAN_W-1:0]    chan_mem [IN_CHANS];
  logic [15:0]          silence_ticks;
  logic [15:0]          send_ticks;
  logic [SEND_W-1:0]    send_interval;
  logic [TIMEOUT_W-1:0] silence_limit;

  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   rx_hold_req = 0;
  int   rx_hold_left = 0;
  int   errors = 0;
  int   quiet_cycles = 0;
  logic s_taken = 1'b0;

  crsf_rc_frame_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
  endtask

  function automatic logic [CHAN_W-1:0] to_scaled(input logic [CHAN_W-1:0] us);
    int x;
    x = us;
    if (x < 1000) x = 1000;
    if (x > 2000) x = 2000;
    return CHAN_W'(172 + ((x - 1000) * 1639) / 1000);
  endfunction

  // apply one accepted request to the mirror and queue the frame it sends
  function automatic void advance_encoder(input radio_item_t it);
    logic [PAYLOAD_BITS-1:0] payload;
    logic [7:0]              frame [FRAME_LEN];
    logic [CHAN_W-1:0]       us;
    logic [CHAN_W-1:0]       v;
    logic [7:0]              crc;
    logic                    fs;
    frame_byte_t             fb;
    if (it.op == OP_PACKET) begin
      for (int i = 0; i < IN_CHANS; i++) chan_mem[i] = it.chans[CHAN_W*i +: CHAN_W];
      silence_ticks = '0;
      return;
    end
    if (silence_ticks != 16'hFFFF) silence_ticks++;
    if (send_ticks != 16'hFFFF) send_ticks++;
    if (send_ticks < {6'd0, send_interval}) return;
    send_ticks = '0;
    fs = silence_ticks > silence_limit;

    // eleven bits per channel, lsb first
    payload = '0;
    for (int i = 0; i < IN_CHANS; i++) begin
      if (fs) us = (i == THROTTLE_IDX) ? CH_MIN : CH_MID;
      else us = chan_mem[i];
      v = to_scaled(us);
      payload[VAL_W*i +: VAL_W] = v[VAL_W-1:0];
    end
    frame[0] = FRAME_ADDR;
    frame[1] = FRAME_SIZE;
    frame[2] = FRAME_TYPE;
    for (int k = 0; k < PAYLOAD_BYTES; k++) frame[3+k] = payload[8*k +: 8];

    // crc-8 over type and payload
    crc = 8'h00;
    for (int j = 2; j < FRAME_LEN - 1; j++) begin
      crc = crc ^ frame[j];
      for (int b = 0; b < 8; b++) crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    frame[FRAME_LEN-1] = crc;

    for (int j = 0; j < FRAME_LEN; j++) begin
      fb.data = frame[j];
      fb.last = (j == FRAME_LEN - 1);
      fb.failsafe = fs;
      frame_bytes_q.push_back(fb);
    end
  endfunction

  // mostly in range, some clamped from either side, some anything
  function automatic logic [CHAN_W-1:0] pick_pulse();
    case ($urandom_range(9))
      0: return CHAN_W'($urandom_range(65535));
      1: return CHAN_W'($urandom_range(999));
      2: return CH_MIN;
      3: return CH_MAX;
      4: return CHAN_W'($urandom_range(65535, 2001));
      default: return CHAN_W'($urandom_range(2000, 1000));
    endcase
  endfunction

  function automatic void add_item(input logic op, input logic [IN_CHANS*CHAN_W-1:0] chans);
    radio_item_t it;
    it.op = op;
    it.chans = chans;
    radio_items_q.push_back(it);
  endfunction

  function automatic void add_random(input logic op);
    logic [IN_CHANS*CHAN_W-1:0] chans;
    for (int i = 0; i < IN_CHANS; i++) chans[CHAN_W*i +: CHAN_W] = pick_pulse();
    add_item(op, chans);
  endfunction

  task automatic settle();
    while (radio_items_q.size() != 0 || frame_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEND_INTERVAL) send_interval = val[SEND_W-1:0];
    else silence_limit = val[TIMEOUT_W-1:0];
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] timeout,
                           input int n_items, input int tx_pct, input int rx_pct,
                           input int pkt_pct);
    settle();
    write_reg(REG_SEND_INTERVAL, interval);
    write_reg(REG_SILENCE_LIMIT, timeout);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n_items) add_random(($urandom_range(99) < pkt_pct) ? OP_PACKET : OP_TICK);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_taken) begin
      if (radio_items_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= radio_items_q[0].op;
        s_axis_tdata <= radio_items_q[0].chans;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // byte receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // accepted requests feed the mirror, accepted bytes are checked
  always @(posedge clk) begin
    frame_byte_t want;
    s_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      advance_encoder(radio_items_q.pop_front());
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frame_bytes_q.size() == 0) begin
        report_mismatch("byte with no frame pending", m_axis_tdata, 0);
      end else begin
        want = frame_bytes_q.pop_front();
        if (m_axis_tdata !== want.data) report_mismatch("frame_byte", m_axis_tdata, want.data);
        if (m_axis_tlast !== want.last) report_mismatch("frame_last", m_axis_tlast, want.last);
        if (m_axis_tuser !== want.failsafe) begin
          report_mismatch("in_failsafe", m_axis_tuser, want.failsafe);
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // mirror starts from the reset state
    for (int i = 0; i < IN_CHANS; i++) chan_mem[i] = (i == THROTTLE_IDX) ? CH_MIN : CH_MID;
    silence_ticks = '0;
    send_ticks = '0;
    send_interval = SEND_INTERVAL_RST;
    silence_limit = SILENCE_LIMIT_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: clamping at both ends, one frame after ten ticks
    add_item(OP_PACKET, {16'd1001, 16'd1500, 16'd2001, 16'd2000,
                         16'd1000, 16'd999, 16'hFFFF, 16'd0});
    repeat (10) add_item(OP_TICK, '0);

    // zero interval sends on every tick, failsafe once past the timeout
    settle();
    write_reg(REG_SEND_INTERVAL, 16'd0);
    write_reg(REG_SILENCE_LIMIT, 16'd2);
    add_item(OP_PACKET, {16'd1000, 16'd2000, 16'd65534, 16'd1750,
                         16'd1234, 16'd32768, 16'd1, 16'd1999});
    repeat (3) add_item(OP_TICK, {IN_CHANS{16'hFFFF}});

    // upper write bits dropped, zero timeout gives failsafe on the first tick
    settle();
    write_reg(REG_SEND_INTERVAL, 16'hFC01);
    write_reg(REG_SILENCE_LIMIT, 16'd0);
    add_random(OP_PACKET);
    add_item(OP_TICK, '0);

    // random traffic under each idling mix
    run_phase(16'd1, 16'd3, 80, 0, 0, 40);
    run_phase(16'd3, 16'd20, 70, 82, 0, 30);
    run_phase(16'd2, 16'd8, 70, 0, 82, 35);
    run_phase(16'd4, 16'hFFFF, 60, 17, 17, 30);

    // receiver holds off while ticks keep coming, input side must stall
    run_phase(16'd1, 16'd1000, 0, 0, 0, 0);
    rx_hold_req = 400;
    repeat (40) add_random(($urandom_range(99) < 25) ? OP_PACKET : OP_TICK);

    settle();
    if (errors == 0 && frame_bytes_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
